### sv/sabb_pkg.sv
// shared types and constants for the sprite additive blend blitter
// no dependencies; used by every module of the block
package sabb_pkg;

   localparam int LINE_STRIDE = 512;
   localparam int FB_ROWS     = 512;
   localparam int FB_SIZE     = LINE_STRIDE * FB_ROWS;

   localparam int ADDR_W     = 18;
   localparam int PIX_W      = 16;
   localparam int CHAN_W     = 5;
   localparam int POS_W      = 9;
   localparam int SIZE_W     = 10;
   localparam int CNT_W      = 9;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 10;
   localparam int MAX_SIZE   = 512;
   localparam int LIN_W      = $clog2((2 * MAX_SIZE) * LINE_STRIDE + 2 * MAX_SIZE);
   localparam int FB_AW      = $clog2(FB_SIZE);

   localparam int QUEUE_DEPTH = 2;

   localparam logic [CSR_IDX_W-1:0] REG_DEST_X        = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_DEST_Y        = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] REG_SPRITE_WIDTH  = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] REG_SPRITE_HEIGHT = CSR_IDX_W'(3);

   localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(64);

   localparam logic [PIX_W-1:0]  PIX_CLEAR = 16'h0000;
   localparam logic [PIX_W-1:0]  PIX_FLAG  = 16'h8000;
   localparam logic [CHAN_W-1:0] CHAN_MAX  = 5'd31;

   typedef enum logic [1:0] {
      OP_SKIP,
      OP_COPY,
      OP_BLEND
   } op_type;

   typedef struct packed {
      logic [ADDR_W-1:0] fb_address;
      op_type            op;
      logic [PIX_W-1:0]  texel;
      logic [PIX_W-1:0]  dest_pixel;
      logic              last_pixel;
   } job_type;

   typedef struct packed {
      logic                  valid;
      logic [CSR_IDX_W-1:0]  index;
      logic [CSR_DATA_W-1:0] data;
   } csr_wr_type;

endpackage

### sv/sabb_front.sv
// front end: config registers, column/row walk, address and texel classification
// depends on sabb_pkg
module sabb_front (
   input  logic                   clock,
   input  logic                   reset,
   input  sabb_pkg::csr_wr_type   csr_wr,
   input  logic                   req_valid,
   input  logic                   queue_full,
   input  logic [sabb_pkg::PIX_W-1:0] req_texel,
   input  logic [sabb_pkg::PIX_W-1:0] req_dest_pixel,
   output logic                   req_stall,
   output logic                   push,
   output sabb_pkg::job_type      push_job
);

   logic [sabb_pkg::POS_W-1:0]  dest_x_ff, dest_x_in;
   logic [sabb_pkg::POS_W-1:0]  dest_y_ff, dest_y_in;
   logic [sabb_pkg::SIZE_W-1:0] width_ff, width_in;
   logic [sabb_pkg::SIZE_W-1:0] height_ff, height_in;
   logic [sabb_pkg::CNT_W-1:0]  col_ff, col_in;
   logic [sabb_pkg::CNT_W-1:0]  row_ff, row_in;

   logic [sabb_pkg::SIZE_W-1:0] w_eff, h_eff;
   logic [sabb_pkg::SIZE_W-1:0] col_next, row_next;
   logic                        end_row, end_col;
   logic [sabb_pkg::SIZE_W-1:0] y_sum, x_sum;
   logic [sabb_pkg::LIN_W-1:0]  linear;
   logic                        csr_hit;

   function automatic logic [sabb_pkg::SIZE_W-1:0] clamp_size(
      input logic [sabb_pkg::SIZE_W-1:0] v);
      logic [sabb_pkg::SIZE_W-1:0] r;
      if (v == '0) begin
         r = sabb_pkg::SIZE_W'(1);
      end else if (v > sabb_pkg::SIZE_W'(sabb_pkg::MAX_SIZE)) begin
         r = sabb_pkg::SIZE_W'(sabb_pkg::MAX_SIZE);
      end else begin
         r = v;
      end
      return r;
   endfunction

   assign req_stall = queue_full;
   assign push      = req_valid & ~queue_full;

   assign w_eff    = clamp_size(width_ff);
   assign h_eff    = clamp_size(height_ff);
   assign col_next = {1'b0, col_ff} + sabb_pkg::SIZE_W'(1);
   assign row_next = {1'b0, row_ff} + sabb_pkg::SIZE_W'(1);
   assign end_row  = (col_next >= w_eff);
   assign end_col  = (row_next >= h_eff);

   // wrap modulo framebuffer size by keeping the low address bits
   assign y_sum  = {1'b0, dest_y_ff} + {1'b0, row_ff};
   assign x_sum  = {1'b0, dest_x_ff} + {1'b0, col_ff};
   assign linear = sabb_pkg::LIN_W'(y_sum) * sabb_pkg::LIN_W'(sabb_pkg::LINE_STRIDE)
                 + sabb_pkg::LIN_W'(x_sum);

   always_comb begin
      push_job.fb_address = sabb_pkg::ADDR_W'(linear[sabb_pkg::FB_AW-1:0]);
      push_job.texel      = req_texel;
      push_job.dest_pixel = req_dest_pixel;
      push_job.last_pixel = end_row & end_col;
      if (req_texel == sabb_pkg::PIX_CLEAR) begin
         push_job.op = sabb_pkg::OP_SKIP;
      end else if ((req_dest_pixel & sabb_pkg::PIX_FLAG) == sabb_pkg::PIX_CLEAR) begin
         push_job.op = sabb_pkg::OP_COPY;
      end else begin
         push_job.op = sabb_pkg::OP_BLEND;
      end
   end

   always_comb begin
      dest_x_in = dest_x_ff;
      dest_y_in = dest_y_ff;
      width_in  = width_ff;
      height_in = height_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      csr_hit   = 1'b0;
      if (csr_wr.valid) begin
         unique case (csr_wr.index)
            sabb_pkg::REG_DEST_X: begin
               dest_x_in = csr_wr.data[sabb_pkg::POS_W-1:0];
               csr_hit   = 1'b1;
            end
            sabb_pkg::REG_DEST_Y: begin
               dest_y_in = csr_wr.data[sabb_pkg::POS_W-1:0];
               csr_hit   = 1'b1;
            end
            sabb_pkg::REG_SPRITE_WIDTH: begin
               width_in = csr_wr.data[sabb_pkg::SIZE_W-1:0];
               csr_hit  = 1'b1;
            end
            sabb_pkg::REG_SPRITE_HEIGHT: begin
               height_in = csr_wr.data[sabb_pkg::SIZE_W-1:0];
               csr_hit   = 1'b1;
            end
            default: csr_hit = 1'b0;
         endcase
      end
      if (csr_hit) begin
         col_in = '0;
         row_in = '0;
      end else if (push) begin
         if (end_row) begin
            col_in = '0;
            row_in = end_col ? '0 : row_next[sabb_pkg::CNT_W-1:0];
         end else begin
            col_in = col_next[sabb_pkg::CNT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dest_x_ff <= '0;
         dest_y_ff <= '0;
         width_ff  <= sabb_pkg::SIZE_RESET;
         height_ff <= sabb_pkg::SIZE_RESET;
         col_ff    <= '0;
         row_ff    <= '0;
      end else begin
         dest_x_ff <= dest_x_in;
         dest_y_ff <= dest_y_in;
         width_ff  <= width_in;
         height_ff <= height_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
      end
   end

endmodule

### sv/sabb_queue.sv
// short fifo of classified jobs between front and back ends
// depends on sabb_pkg
module sabb_queue #(
   parameter int DEPTH = sabb_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  sabb_pkg::job_type push_job,
   input  logic              pop,
   output logic              full,
   output logic              not_empty,
   output sabb_pkg::job_type head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   sabb_pkg::job_type entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      if (p == PTR_W'(DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + PTR_W'(1);
      end
      return r;
   endfunction

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? bump(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? bump(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### sv/sabb_back.sv
// back end: copy or saturating additive blend, registered result transfer
// depends on sabb_pkg
module sabb_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        not_empty,
   input  sabb_pkg::job_type           head,
   input  logic                        rsp_stall,
   output logic                        pop,
   output logic                        rsp_valid,
   output logic [sabb_pkg::ADDR_W-1:0] rsp_fb_address,
   output logic [sabb_pkg::PIX_W-1:0]  rsp_write_data,
   output logic                        rsp_write_enable,
   output logic                        rsp_last_pixel
);

   logic                        valid_ff, valid_in;
   logic [sabb_pkg::ADDR_W-1:0] addr_ff;
   logic [sabb_pkg::PIX_W-1:0]  data_ff, data_in;
   logic                        we_ff, we_in;
   logic                        last_ff;
   logic                        load;
   logic [sabb_pkg::PIX_W-1:0]  blend;

   function automatic logic [sabb_pkg::CHAN_W-1:0] sat_add(
      input logic [sabb_pkg::CHAN_W-1:0] a,
      input logic [sabb_pkg::CHAN_W-1:0] b);
      logic [sabb_pkg::CHAN_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[sabb_pkg::CHAN_W] ? sabb_pkg::CHAN_MAX : s[sabb_pkg::CHAN_W-1:0];
   endfunction

   assign load = ~valid_ff | ~rsp_stall;
   assign pop  = not_empty & load;

   assign blend = sabb_pkg::PIX_FLAG
                | {1'b0,
                   sat_add(head.texel[14:10], head.dest_pixel[14:10]),
                   sat_add(head.texel[9:5], head.dest_pixel[9:5]),
                   sat_add(head.texel[4:0], head.dest_pixel[4:0])};

   always_comb begin
      case (head.op)
         sabb_pkg::OP_COPY: begin
            data_in = head.texel;
            we_in   = 1'b1;
         end
         sabb_pkg::OP_BLEND: begin
            data_in = blend;
            we_in   = 1'b1;
         end
         default: begin
            data_in = sabb_pkg::PIX_CLEAR;
            we_in   = 1'b0;
         end
      endcase
   end

   assign valid_in = load ? not_empty : valid_ff;

   always_ff @(posedge clock) begin
      if (pop) begin
         addr_ff <= head.fb_address;
         data_ff <= data_in;
         we_ff   <= we_in;
         last_ff <= head.last_pixel;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_fb_address   = addr_ff;
   assign rsp_write_data   = data_ff;
   assign rsp_write_enable = we_ff;
   assign rsp_last_pixel   = last_ff;

endmodule

### sv/sprite_additive_blend_blitter_core.sv
// top level of the rgb1555 sprite blitter with saturating additive blend
// depends on sabb_pkg, sabb_front, sabb_queue, sabb_back
//
// channel  direction  handshake          payload
// req      in         req_valid/stall    texel, dest_pixel
// rsp      out        rsp_valid/stall    fb_address, write_data, write_enable, last_pixel
// csr      in         csr_valid/ready    csr_index, csr_data
//
// one texel per cycle while rsp is not stalled; each transfer is registered twice from req to rsp
// (front end into the queue, then the back end output register)
// the queue depth sets how many texels the front takes while rsp is stalled
// reset returns registers to defaults and restarts the sprite walk
// any register write also restarts the sprite walk; csr_ready is always high
module sprite_additive_blend_blitter_core #(
   parameter int QUEUE_DEPTH = sabb_pkg::QUEUE_DEPTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [sabb_pkg::PIX_W-1:0]      req_texel,
   input  logic [sabb_pkg::PIX_W-1:0]      req_dest_pixel,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [sabb_pkg::ADDR_W-1:0]     rsp_fb_address,
   output logic [sabb_pkg::PIX_W-1:0]      rsp_write_data,
   output logic                            rsp_write_enable,
   output logic                            rsp_last_pixel,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [sabb_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [sabb_pkg::CSR_DATA_W-1:0] csr_data
);

   sabb_pkg::csr_wr_type csr_wr;
   sabb_pkg::job_type    push_job;
   sabb_pkg::job_type    head;
   logic                 push;
   logic                 pop;
   logic                 queue_full;
   logic                 not_empty;

   assign csr_ready    = 1'b1;
   assign csr_wr.valid = csr_valid;
   assign csr_wr.index = csr_index;
   assign csr_wr.data  = csr_data;

   sabb_front u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_wr         (csr_wr),
      .req_valid      (req_valid),
      .queue_full     (queue_full),
      .req_texel      (req_texel),
      .req_dest_pixel (req_dest_pixel),
      .req_stall      (req_stall),
      .push           (push),
      .push_job       (push_job)
   );

   sabb_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (push_job),
      .pop       (pop),
      .full      (queue_full),
      .not_empty (not_empty),
      .head      (head)
   );

   sabb_back u_back (
      .clock            (clock),
      .reset            (reset),
      .not_empty        (not_empty),
      .head             (head),
      .rsp_stall        (rsp_stall),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_fb_address   (rsp_fb_address),
      .rsp_write_data   (rsp_write_data),
      .rsp_write_enable (rsp_write_enable),
      .rsp_last_pixel   (rsp_last_pixel)
   );

endmodule

### tb/sprite_additive_blend_blitter_core_tb.sv
// self-checking testbench for sprite_additive_blend_blitter_core: texel/pixel transfers
// are predicted in-line and matched against rsp transfers in order, under random gaps/stalls
// depends on sabb_pkg and sprite_additive_blend_blitter_core
`timescale 1ns / 1ps

module sprite_additive_blend_blitter_core_tb;

   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned TARGET_PIXELS = 2000;

   typedef struct packed {
      logic [sabb_pkg::PIX_W-1:0] texel;
      logic [sabb_pkg::PIX_W-1:0] dest_pixel;
   } pixel_pair_type;

   typedef struct packed {
      logic [sabb_pkg::ADDR_W-1:0] fb_address;
      logic [sabb_pkg::PIX_W-1:0]  write_data;
      logic                        write_enable;
      logic                        last_pixel;
   } blit_write_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_stall;
   logic [sabb_pkg::PIX_W-1:0]      req_texel = '0;
   logic [sabb_pkg::PIX_W-1:0]      req_dest_pixel = '0;
   logic                            rsp_valid;
   logic                            rsp_stall = 1'b0;
   logic [sabb_pkg::ADDR_W-1:0]     rsp_fb_address;
   logic [sabb_pkg::PIX_W-1:0]      rsp_write_data;
   logic                            rsp_write_enable;
   logic                            rsp_last_pixel;
   logic                            csr_valid = 1'b0;
   logic                            csr_ready;
   logic [sabb_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [sabb_pkg::CSR_DATA_W-1:0] csr_data = '0;

   pixel_pair_type pending_pixels[$];
   blit_write_type expected_writes[$];

   // blitter state as the block should hold it
   int unsigned pos_x, pos_y, width_reg, height_reg;
   int unsigned blit_col, blit_row;

   int unsigned failures;
   int unsigned cycle_count;
   int unsigned queued_pixels;
   int          burst_left = 8;
   int          gap_left;
   int          stall_mode;
   int          stall_count;

   sprite_additive_blend_blitter_core dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_texel       (req_texel),
      .req_dest_pixel  (req_dest_pixel),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_fb_address  (rsp_fb_address),
      .rsp_write_data  (rsp_write_data),
      .rsp_write_enable(rsp_write_enable),
      .rsp_last_pixel  (rsp_last_pixel),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always #5 clock = ~clock;

   function automatic int unsigned eff_size(input int unsigned v);
      if (v == 0) return 1;
      if (v > sabb_pkg::MAX_SIZE) return sabb_pkg::MAX_SIZE;
      return v;
   endfunction

   function automatic blit_write_type blit_pixel(input logic [sabb_pkg::PIX_W-1:0] texel,
                                                input logic [sabb_pkg::PIX_W-1:0] dst);
      blit_write_type w;
      int unsigned wd, ht, lin;
      logic        end_row, end_sprite;
      logic [sabb_pkg::CHAN_W:0] sum;
      int          c;
      wd = eff_size(width_reg);
      ht = eff_size(height_reg);
      end_row = (blit_col + 1 >= wd);
      end_sprite = (blit_row + 1 >= ht);
      lin = ((pos_y + blit_row) * sabb_pkg::LINE_STRIDE + pos_x + blit_col)
            % sabb_pkg::FB_SIZE;
      w.fb_address = sabb_pkg::ADDR_W'(lin);
      w.write_data = sabb_pkg::PIX_CLEAR;
      w.write_enable = 1'b0;
      w.last_pixel = end_row & end_sprite;
      if (texel != sabb_pkg::PIX_CLEAR) begin
         w.write_enable = 1'b1;
         if ((dst & sabb_pkg::PIX_FLAG) == sabb_pkg::PIX_CLEAR) begin
            w.write_data = texel;
         end else begin
            w.write_data = sabb_pkg::PIX_FLAG;
            for (c = 0; c < 3; c++) begin
               sum = {1'b0, texel[c*sabb_pkg::CHAN_W +: sabb_pkg::CHAN_W]}
                   + {1'b0, dst[c*sabb_pkg::CHAN_W +: sabb_pkg::CHAN_W]};
               w.write_data[c*sabb_pkg::CHAN_W +: sabb_pkg::CHAN_W] =
                  (sum > sabb_pkg::CHAN_MAX) ? sabb_pkg::CHAN_MAX
                                             : sum[sabb_pkg::CHAN_W-1:0];
            end
         end
      end
      if (end_row) begin
         blit_col = 0;
         blit_row = end_sprite ? 0 : (blit_row + 1) % (1 << sabb_pkg::CNT_W);
      end else begin
         blit_col = (blit_col + 1) % (1 << sabb_pkg::CNT_W);
      end
      return w;
   endfunction

   function automatic logic [sabb_pkg::PIX_W-1:0] rand_pixel();
      case ($urandom_range(0, 7))
         0: return sabb_pkg::PIX_CLEAR;
         1: return {1'($urandom_range(0, 1)), 5'($urandom_range(24, 31)),
                    5'($urandom_range(24, 31)), 5'($urandom_range(24, 31))};
         default: return sabb_pkg::PIX_W'($urandom);
      endcase
   endfunction

   task automatic add_pixel(input logic [sabb_pkg::PIX_W-1:0] texel,
                            input logic [sabb_pkg::PIX_W-1:0] dst);
      pixel_pair_type p;
      p.texel = texel;
      p.dest_pixel = dst;
      pending_pixels.push_back(p);
      queued_pixels++;
   endtask

   // csr_valid stays high across back-to-back writes; end_writes drops it
   task automatic write_reg(input logic [sabb_pkg::CSR_IDX_W-1:0] idx,
                            input logic [sabb_pkg::CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         sabb_pkg::REG_DEST_X:        pos_x = val % (1 << sabb_pkg::POS_W);
         sabb_pkg::REG_DEST_Y:        pos_y = val % (1 << sabb_pkg::POS_W);
         sabb_pkg::REG_SPRITE_WIDTH:  width_reg = val;
         sabb_pkg::REG_SPRITE_HEIGHT: height_reg = val;
         default: return;
      endcase
      blit_col = 0;
      blit_row = 0;
   endtask

   task automatic end_writes();
      csr_valid <= 1'b0;
   endtask

   task automatic wait_idle();
      do @(posedge clock); while (pending_pixels.size() != 0 || expected_writes.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   // driver: bursts of transfers with random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_writes.push_back(blit_pixel(req_texel, req_dest_pixel));
            pending_pixels.delete(0);
         end
         if (!(req_valid && req_stall)) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_pixels.size() != 0) begin
               req_valid <= 1'b1;
               req_texel <= pending_pixels[0].texel;
               req_dest_pixel <= pending_pixels[0].dest_pixel;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 24);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: check each rsp transfer, stall on a pattern of its own
   always @(posedge clock) begin
      blit_write_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_writes.size() == 0) begin
            $error("unexpected transfer: fb_address %h write_data %h", rsp_fb_address,
                   rsp_write_data);
            failures++;
         end else begin
            e = expected_writes.pop_front();
            if (rsp_fb_address !== e.fb_address) begin
               $error("fb_address: expected %h, actual %h", e.fb_address, rsp_fb_address);
               failures++;
            end
            if (rsp_write_data !== e.write_data) begin
               $error("write_data: expected %h, actual %h", e.write_data, rsp_write_data);
               failures++;
            end
            if (rsp_write_enable !== e.write_enable) begin
               $error("write_enable: expected %b, actual %b", e.write_enable, rsp_write_enable);
               failures++;
            end
            if (rsp_last_pixel !== e.last_pixel) begin
               $error("last_pixel: expected %b, actual %b", e.last_pixel, rsp_last_pixel);
               failures++;
            end
         end
      end
      if (stall_count == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_count = $urandom_range(20, 120);
      end else begin
         stall_count--;
      end
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= ($urandom_range(0, 3) != 0);
         default: rsp_stall <= ~rsp_stall;
      endcase
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("sprite_additive_blend_blitter_core_tb: FAIL");
         $finish;
      end
   end

   initial begin
      int unsigned wd, ht, n, i;
      pos_x = 0;
      pos_y = 0;
      width_reg = sabb_pkg::SIZE_RESET;
      height_reg = sabb_pkg::SIZE_RESET;
      blit_col = 0;
      blit_row = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // default 64x64 sprite at the origin: transparent, copy, blend and saturation
      add_pixel(sabb_pkg::PIX_CLEAR, sabb_pkg::PIX_CLEAR);
      add_pixel(sabb_pkg::PIX_CLEAR, 16'hFFFF);
      add_pixel(16'hFFFF, sabb_pkg::PIX_CLEAR);
      add_pixel(16'h7FFF, sabb_pkg::PIX_FLAG);
      add_pixel(16'h7FFF, 16'hFFFF);
      add_pixel(16'h0421, 16'h8842);
      add_pixel(16'h8001, 16'h7FFF);
      add_pixel(16'h7C00, 16'h83FF);
      wait_idle();

      // zero sizes act as one: every transfer ends the sprite
      write_reg(sabb_pkg::REG_SPRITE_WIDTH, '0);
      write_reg(sabb_pkg::REG_SPRITE_HEIGHT, '0);
      end_writes();
      add_pixel(16'h0001, 16'h8001);
      add_pixel(sabb_pkg::PIX_CLEAR, 16'h8000);
      add_pixel(16'h801F, 16'h801F);
      wait_idle();

      // far corner with upper data bits set: address wraps in both directions
      write_reg(sabb_pkg::REG_DEST_X, '1);
      write_reg(sabb_pkg::REG_DEST_Y, '1);
      write_reg(sabb_pkg::REG_SPRITE_WIDTH, 10'd3);
      write_reg(sabb_pkg::REG_SPRITE_HEIGHT, 10'd2);
      end_writes();
      for (i = 0; i < 7; i++) add_pixel(rand_pixel(), rand_pixel());
      wait_idle();

      // oversize width clamps to a full 512-texel row
      write_reg(sabb_pkg::REG_SPRITE_WIDTH, '1);
      write_reg(sabb_pkg::REG_SPRITE_HEIGHT, 10'd1);
      write_reg(sabb_pkg::REG_DEST_X, 10'd0);
      write_reg(sabb_pkg::REG_DEST_Y, 10'd0);
      end_writes();
      for (i = 0; i < 2 * sabb_pkg::MAX_SIZE + 3; i++) add_pixel(rand_pixel(), rand_pixel());
      wait_idle();

      // tall sprite at full height
      write_reg(sabb_pkg::REG_SPRITE_WIDTH, 10'd1);
      write_reg(sabb_pkg::REG_SPRITE_HEIGHT, 10'(sabb_pkg::MAX_SIZE));
      write_reg(sabb_pkg::REG_DEST_X, 10'($urandom_range(0, 1023)));
      end_writes();
      for (i = 0; i < sabb_pkg::MAX_SIZE + 2; i++) add_pixel(rand_pixel(), rand_pixel());
      wait_idle();

      while (queued_pixels < TARGET_PIXELS) begin
         if ($urandom_range(0, 1))
            write_reg(sabb_pkg::REG_DEST_X, sabb_pkg::CSR_DATA_W'($urandom));
         if ($urandom_range(0, 1))
            write_reg(sabb_pkg::REG_DEST_Y, sabb_pkg::CSR_DATA_W'($urandom));
         if ($urandom_range(0, 15) == 0) begin
            write_reg(sabb_pkg::REG_SPRITE_WIDTH, 10'($urandom_range(500, 1023)));
            write_reg(sabb_pkg::REG_SPRITE_HEIGHT, 10'($urandom_range(0, 1)));
         end else begin
            if ($urandom_range(0, 2) != 0)
               write_reg(sabb_pkg::REG_SPRITE_WIDTH, 10'($urandom_range(0, 9)));
            if ($urandom_range(0, 2) != 0)
               write_reg(sabb_pkg::REG_SPRITE_HEIGHT, 10'($urandom_range(0, 6)));
         end
         if ($urandom_range(0, 5) == 0)
            write_reg(sabb_pkg::CSR_IDX_W'($urandom_range(sabb_pkg::REG_SPRITE_HEIGHT + 1,
                                                          (1 << sabb_pkg::CSR_IDX_W) - 1)),
                      sabb_pkg::CSR_DATA_W'($urandom));
         end_writes();
         wd = eff_size(width_reg);
         ht = eff_size(height_reg);
         if (wd * ht > 64) n = wd * ht + $urandom_range(0, wd);
         else n = wd * ht * $urandom_range(1, 3) + $urandom_range(0, wd);
         for (i = 0; i < n; i++) add_pixel(rand_pixel(), rand_pixel());
         wait_idle();
      end

      if (failures == 0) begin
         $display("sprite_additive_blend_blitter_core_tb: PASS");
      end else begin
         $display("sprite_additive_blend_blitter_core_tb: FAIL");
      end
      $finish;
   end

endmodule
